[hw/rtl/bld_pkg.sv]
package bld_pkg;

    localparam int SMP_W   = 32;
    localparam int LVL_W   = 28;
    localparam int SUM_W   = 64;
    localparam int CNT_W   = 8;
    localparam int TIME_W  = 32;
    localparam int MS_W    = 16;
    localparam int SHIFT_W = 5;
    localparam int CODE_W  = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QLVL_W  = 3;

    localparam logic [LVL_W-1:0] LVL_SAT = {LVL_W{1'b1}};

    localparam logic [2:0] REG_SAMPLE_SHIFT     = 3'd0;
    localparam logic [2:0] REG_SPEECH_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_QUIET_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_MIN_SPEECH_MS    = 3'd3;
    localparam logic [2:0] REG_SHORT_MAX_MS     = 3'd4;
    localparam logic [2:0] REG_COOLDOWN_MS      = 3'd5;
    localparam logic [2:0] REG_SIGNAL_THRESHOLD = 3'd6;

    localparam logic [SHIFT_W-1:0] RST_SAMPLE_SHIFT     = 5'd14;
    localparam logic [LVL_W-1:0]   RST_SPEECH_THRESHOLD = 28'd800;
    localparam logic [LVL_W-1:0]   RST_QUIET_THRESHOLD  = 28'd400;
    localparam logic [MS_W-1:0]    RST_MIN_SPEECH_MS    = 16'd120;
    localparam logic [MS_W-1:0]    RST_SHORT_MAX_MS     = 16'd650;
    localparam logic [MS_W-1:0]    RST_COOLDOWN_MS      = 16'd1800;
    localparam logic [LVL_W-1:0]   RST_SIGNAL_THRESHOLD = 28'd50;

    localparam logic [CODE_W-1:0] EV_NONE       = 3'd0;
    localparam logic [CODE_W-1:0] EV_START      = 3'd1;
    localparam logic [CODE_W-1:0] EV_TOO_SHORT  = 3'd2;
    localparam logic [CODE_W-1:0] EV_SHORT_CMD  = 3'd3;
    localparam logic [CODE_W-1:0] EV_LONG_CMD   = 3'd4;
    localparam logic [CODE_W-1:0] EV_SUPPRESSED = 3'd5;

    typedef struct packed {
        logic [SHIFT_W-1:0] sample_shift;
        logic [LVL_W-1:0]   speech_threshold;
        logic [LVL_W-1:0]   quiet_threshold;
        logic [MS_W-1:0]    min_speech_ms;
        logic [MS_W-1:0]    short_max_ms;
        logic [MS_W-1:0]    cooldown_ms;
        logic [LVL_W-1:0]   signal_threshold;
    } t_cfg;

    typedef struct packed {
        logic [SMP_W-1:0]  spread;
        logic [LVL_W-1:0]  peak;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] now;
    } t_burst_rec;

    typedef struct packed {
        logic [LVL_W-1:0]  level_spread;
        logic [LVL_W-1:0]  level_peak;
        logic [LVL_W-1:0]  level_rms;
        logic              signal_seen;
        logic              speech_active;
        logic [CODE_W-1:0] event_code;
        logic [TIME_W-1:0] speech_length_ms;
    } t_result;

endpackage

[hw/rtl/bld_front.sv]
module bld_front import bld_pkg::*; #(
    parameter int MAX_BURST = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [SMP_W-1:0]  i_raw_sample,
    input  logic                     i_burst_end,
    input  logic [TIME_W-1:0]        i_now_ms,
    input  logic [SHIFT_W-1:0]       i_sample_shift,
    input  logic [QLVL_W-1:0]        i_q_level,
    output logic                     o_push,
    output t_burst_rec               o_push_rec
);

    localparam int CW = $clog2(MAX_BURST + 1);

    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic signed [SMP_W-1:0] r_s1_smp;
    logic [SMP_W-1:0]        r_s1_abs;
    logic [TIME_W-1:0]       r_s1_now;

    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic signed [SMP_W-1:0] r_s2_smp;
    logic [SMP_W-1:0]        r_s2_abs;
    logic [SUM_W-1:0]        r_s2_sq;
    logic [TIME_W-1:0]       r_s2_now;

    logic signed [SMP_W-1:0] r_min;
    logic signed [SMP_W-1:0] r_max;
    logic [LVL_W-1:0]        r_peak;
    logic [SUM_W-1:0]        r_sum;
    logic [CW-1:0]           r_cnt;

    logic signed [SMP_W-1:0] n_min;
    logic signed [SMP_W-1:0] n_max;
    logic [LVL_W-1:0]        n_peak;
    logic [SUM_W-1:0]        n_sum;
    logic [CW-1:0]           n_cnt;

    logic                    accept;
    logic                    take;
    logic                    first;
    logic signed [SMP_W-1:0] shifted;
    logic [SUM_W:0]          sum_ext;
    logic [QLVL_W-1:0]       pending;
    logic [SMP_W:0]          spread_ext;

    assign pending    = i_q_level + {{(QLVL_W-1){1'b0}}, r_s1_valid & r_s1_last}
                                  + {{(QLVL_W-1){1'b0}}, r_s2_valid & r_s2_last};
    assign o_in_stall = (pending >= QLVL_W'(QDEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign shifted    = i_raw_sample >>> i_sample_shift;

    always_comb begin
        take    = (r_cnt < CW'(MAX_BURST));
        first   = (r_cnt == '0);
        sum_ext = {1'b0, r_sum} + {1'b0, r_s2_sq};
        n_min   = r_min;
        n_max   = r_max;
        n_peak  = r_peak;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        if (take) begin
            if (first || (r_s2_smp < r_min)) begin
                n_min = r_s2_smp;
            end
            if (first || (r_s2_smp > r_max)) begin
                n_max = r_s2_smp;
            end
            if (r_s2_abs > {{(SMP_W-LVL_W){1'b0}}, r_peak}) begin
                n_peak = (r_s2_abs[SMP_W-1:LVL_W] != '0) ? LVL_SAT : r_s2_abs[LVL_W-1:0];
            end
            n_sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
            n_cnt = r_cnt + CW'(1);
        end
        spread_ext = {n_max[SMP_W-1], n_max} - {n_min[SMP_W-1], n_min};
    end

    assign o_push           = r_s2_valid && r_s2_last;
    assign o_push_rec.spread = spread_ext[SMP_W-1:0];
    assign o_push_rec.peak   = n_peak;
    assign o_push_rec.sum    = n_sum;
    assign o_push_rec.count  = CNT_W'(n_cnt);
    assign o_push_rec.now    = r_s2_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_min      <= '0;
            r_max      <= '0;
            r_peak     <= '0;
            r_sum      <= '0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_min  <= '0;
                    r_max  <= '0;
                    r_peak <= '0;
                    r_sum  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_min  <= n_min;
                    r_max  <= n_max;
                    r_peak <= n_peak;
                    r_sum  <= n_sum;
                    r_cnt  <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= i_burst_end;
        r_s1_smp  <= shifted;
        r_s1_abs  <= shifted[SMP_W-1] ? (~shifted + SMP_W'(1)) : shifted;
        r_s1_now  <= i_now_ms;
        r_s2_last <= r_s1_last;
        r_s2_smp  <= r_s1_smp;
        r_s2_abs  <= r_s1_abs;
        r_s2_sq   <= r_s1_abs * r_s1_abs;
        r_s2_now  <= r_s1_now;
    end

endmodule

[hw/rtl/bld_queue.sv]
module bld_queue import bld_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_burst_rec        i_push_rec,
    input  logic              i_pop,
    output logic              o_nonempty,
    output t_burst_rec        o_head,
    output logic [QLVL_W-1:0] o_level
);

    t_burst_rec        r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QLVL_W-1:0] r_level;

    assign o_nonempty = (r_level != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign o_level    = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + QLVL_W'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - QLVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

endmodule

[hw/rtl/bld_back.sv]
module bld_back import bld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_nonempty,
    input  t_burst_rec  i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_result
);

    localparam int DSTEP_W = $clog2(SUM_W);
    localparam int ROOT_W  = SUM_W / 2;
    localparam int RSTEP_W = $clog2(ROOT_W);
    localparam int SREM_W  = ROOT_W + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SQRT,
        S_DECIDE
    } t_state;

    t_state             r_state;
    logic [DSTEP_W-1:0] r_step;
    logic [SMP_W-1:0]   r_spread;
    logic [LVL_W-1:0]   r_peak;
    logic [TIME_W-1:0]  r_now;
    logic [CNT_W-1:0]   r_div;
    logic [CNT_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_quo;
    logic [SREM_W-1:0]  r_srem;
    logic [ROOT_W-1:0]  r_root;
    logic               r_in_speech;
    logic [TIME_W-1:0]  r_speech_start;
    logic [TIME_W-1:0]  r_cooldown_until;
    logic               r_signal_flag;
    logic               r_out_valid;
    t_result            r_result;

    logic [CNT_W:0]      div_sh;
    logic                div_ge;
    logic [SREM_W+1:0]   sq_sh;
    logic [SREM_W+1:0]   sq_trial;
    logic                sq_ge;
    logic                out_free;
    logic                sig_hit;
    logic                loud;
    logic                quiet;
    logic [TIME_W-1:0]   dur;
    logic                n_in_speech;
    logic [TIME_W-1:0]   n_speech_start;
    logic [TIME_W-1:0]   n_cooldown_until;
    logic [CODE_W-1:0]   n_code;
    logic [TIME_W-1:0]   n_length;

    assign o_pop       = (r_state == S_IDLE) && i_nonempty;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign div_sh   = {r_rem, r_quo[SUM_W-1]};
    assign div_ge   = (div_sh >= {1'b0, r_div});
    assign sq_sh    = {r_srem, r_quo[SUM_W-1:SUM_W-2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    always_comb begin
        sig_hit          = (r_spread > {{(SMP_W-LVL_W){1'b0}}, i_cfg.signal_threshold});
        loud             = (r_spread > {{(SMP_W-LVL_W){1'b0}}, i_cfg.speech_threshold});
        quiet            = (r_spread < {{(SMP_W-LVL_W){1'b0}}, i_cfg.quiet_threshold});
        dur              = r_now - r_speech_start;
        n_in_speech      = r_in_speech;
        n_speech_start   = r_speech_start;
        n_cooldown_until = r_cooldown_until;
        n_code           = EV_NONE;
        n_length         = '0;
        if (loud) begin
            if (!r_in_speech) begin
                n_in_speech    = 1'b1;
                n_speech_start = r_now;
                n_code         = EV_START;
            end
        end else if (r_in_speech && quiet) begin
            n_in_speech = 1'b0;
            n_length    = dur;
            if (dur < {{(TIME_W-MS_W){1'b0}}, i_cfg.min_speech_ms}) begin
                n_code = EV_TOO_SHORT;
            end else if (r_now < r_cooldown_until) begin
                n_code = EV_SUPPRESSED;
            end else begin
                n_cooldown_until = r_now + {{(TIME_W-MS_W){1'b0}}, i_cfg.cooldown_ms};
                n_code = (dur <= {{(TIME_W-MS_W){1'b0}}, i_cfg.short_max_ms}) ?
                         EV_SHORT_CMD : EV_LONG_CMD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_in_speech      <= 1'b0;
            r_speech_start   <= '0;
            r_cooldown_until <= '0;
            r_signal_flag    <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if ((r_state == S_DECIDE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_nonempty) begin
                        r_spread <= i_head.spread;
                        r_peak   <= i_head.peak;
                        r_now    <= i_head.now;
                        r_div    <= i_head.count;
                        r_rem    <= '0;
                        r_quo    <= i_head.sum;
                        r_step   <= '0;
                        r_root   <= '0;
                        r_state  <= (i_head.count == '0) ? S_DECIDE : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? CNT_W'(div_sh - {1'b0, r_div}) : div_sh[CNT_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], div_ge};
                    r_step <= r_step + DSTEP_W'(1);
                    if (r_step == DSTEP_W'(SUM_W - 1)) begin
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_srem <= sq_ge ? SREM_W'(sq_sh - sq_trial) : sq_sh[SREM_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], sq_ge};
                    r_quo  <= {r_quo[SUM_W-3:0], 2'b00};
                    r_step <= r_step + DSTEP_W'(1);
                    if (r_step[RSTEP_W-1:0] == RSTEP_W'(ROOT_W - 1)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        r_in_speech      <= n_in_speech;
                        r_speech_start   <= n_speech_start;
                        r_cooldown_until <= n_cooldown_until;
                        r_signal_flag    <= r_signal_flag | sig_hit;
                        r_result.level_spread <= (r_spread[SMP_W-1:LVL_W] != '0) ?
                                                 LVL_SAT : r_spread[LVL_W-1:0];
                        r_result.level_peak   <= r_peak;
                        r_result.level_rms    <= (r_root[ROOT_W-1:LVL_W] != '0) ?
                                                 LVL_SAT : r_root[LVL_W-1:0];
                        r_result.signal_seen      <= r_signal_flag | sig_hit;
                        r_result.speech_active    <= n_in_speech;
                        r_result.event_code       <= n_code;
                        r_result.speech_length_ms <= n_length;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/burst_level_speech_detector_top.sv]
// Burst level meter with speech detection. Samples are taken one per clock
// cycle while o_in_stall is low; each burst closed by a sample with burst_end
// set yields one result transfer carrying spread, peak, RMS level and the
// speech event. The per-burst back end loads the burst record, runs the
// bit-serial divider for the mean square and then the bit-serial square root,
// and makes the decision; it takes one burst at a time, and up to four closed
// bursts wait in the queue between the sample accumulator and that back end.
// Input stalls when the queue together with the bursts still in the
// accumulator pipeline would exceed four, so a run of short bursts slows the
// sample rate to the rate at which the back end finishes bursts.
module burst_level_speech_detector_top import bld_pkg::*; #(
    parameter int MAX_BURST = 128
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [SMP_W-1:0]  i_raw_sample,
    input  logic                     i_burst_end,
    input  logic [TIME_W-1:0]        i_now_ms,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [LVL_W-1:0]         o_level_spread,
    output logic [LVL_W-1:0]         o_level_peak,
    output logic [LVL_W-1:0]         o_level_rms,
    output logic                     o_signal_seen,
    output logic                     o_speech_active,
    output logic [CODE_W-1:0]        o_event_code,
    output logic [TIME_W-1:0]        o_speech_length_ms,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    t_cfg              r_cfg;
    logic              cfg_we;
    logic [2:0]        reg_idx;
    logic              push;
    t_burst_rec        push_rec;
    logic              pop;
    logic              nonempty;
    t_burst_rec        head;
    logic [QLVL_W-1:0] q_level;
    t_result           result;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_shift     <= RST_SAMPLE_SHIFT;
            r_cfg.speech_threshold <= RST_SPEECH_THRESHOLD;
            r_cfg.quiet_threshold  <= RST_QUIET_THRESHOLD;
            r_cfg.min_speech_ms    <= RST_MIN_SPEECH_MS;
            r_cfg.short_max_ms     <= RST_SHORT_MAX_MS;
            r_cfg.cooldown_ms      <= RST_COOLDOWN_MS;
            r_cfg.signal_threshold <= RST_SIGNAL_THRESHOLD;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_SAMPLE_SHIFT:     r_cfg.sample_shift     <= pwdata[SHIFT_W-1:0];
                REG_SPEECH_THRESHOLD: r_cfg.speech_threshold <= pwdata[LVL_W-1:0];
                REG_QUIET_THRESHOLD:  r_cfg.quiet_threshold  <= pwdata[LVL_W-1:0];
                REG_MIN_SPEECH_MS:    r_cfg.min_speech_ms    <= pwdata[MS_W-1:0];
                REG_SHORT_MAX_MS:     r_cfg.short_max_ms     <= pwdata[MS_W-1:0];
                REG_COOLDOWN_MS:      r_cfg.cooldown_ms      <= pwdata[MS_W-1:0];
                REG_SIGNAL_THRESHOLD: r_cfg.signal_threshold <= pwdata[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SAMPLE_SHIFT:     prdata = DATA_W'(r_cfg.sample_shift);
            REG_SPEECH_THRESHOLD: prdata = DATA_W'(r_cfg.speech_threshold);
            REG_QUIET_THRESHOLD:  prdata = DATA_W'(r_cfg.quiet_threshold);
            REG_MIN_SPEECH_MS:    prdata = DATA_W'(r_cfg.min_speech_ms);
            REG_SHORT_MAX_MS:     prdata = DATA_W'(r_cfg.short_max_ms);
            REG_COOLDOWN_MS:      prdata = DATA_W'(r_cfg.cooldown_ms);
            REG_SIGNAL_THRESHOLD: prdata = DATA_W'(r_cfg.signal_threshold);
            default:              prdata = '0;
        endcase
    end

    bld_front #(
        .MAX_BURST(MAX_BURST)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_raw_sample   (i_raw_sample),
        .i_burst_end    (i_burst_end),
        .i_now_ms       (i_now_ms),
        .i_sample_shift (r_cfg.sample_shift),
        .i_q_level      (q_level),
        .o_push         (push),
        .o_push_rec     (push_rec)
    );

    bld_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head),
        .o_level    (q_level)
    );

    bld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_nonempty  (nonempty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_level_spread     = result.level_spread;
    assign o_level_peak       = result.level_peak;
    assign o_level_rms        = result.level_rms;
    assign o_signal_seen      = result.signal_seen;
    assign o_speech_active    = result.speech_active;
    assign o_event_code       = result.event_code;
    assign o_speech_length_ms = result.speech_length_ms;

endmodule

[hw/rtl/bld_checker.sv]
module bld_checker import bld_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [LVL_W-1:0]   o_level_spread,
    input logic               o_signal_seen,
    input logic               o_speech_active,
    input logic [CODE_W-1:0]  o_event_code,
    input logic [TIME_W-1:0]  o_speech_length_ms
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_event_code)
            && $stable(o_level_spread))
        else $error("Stalled result transfer was dropped or changed.");

    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_code == EV_START) |-> o_speech_active)
        else $error("Speech start reported without active speech.");

    a_end_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_code == EV_TOO_SHORT || o_event_code == EV_SHORT_CMD
            || o_event_code == EV_LONG_CMD || o_event_code == EV_SUPPRESSED)
        |-> !o_speech_active)
        else $error("Speech end reported while speech still active.");

    a_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_code == EV_NONE || o_event_code == EV_START)
        |-> (o_speech_length_ms == '0))
        else $error("Length reported without a speech end.");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_signal_seen && !i_out_stall ##1 !o_out_valid ##1 o_out_valid
        |-> o_signal_seen)
        else $error("Signal flag cleared between results.");

endmodule

bind burst_level_speech_detector_top bld_checker u_bld_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_level_spread     (o_level_spread),
    .o_signal_seen      (o_signal_seen),
    .o_speech_active    (o_speech_active),
    .o_event_code       (o_event_code),
    .o_speech_length_ms (o_speech_length_ms)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import bld_pkg::*;

    localparam int BURST_CAP    = 128;
    localparam int DRAIN_CYCLES = 150;
    localparam int LIMIT        = 1_000_000;

    typedef enum logic [1:0] {BK_LOUD, BK_QUIET, BK_EDGE, BK_NOISE} t_burst_kind;

    typedef struct packed {
        logic signed [SMP_W-1:0] raw;
        logic                    last;
        logic [TIME_W-1:0]       now;
    } t_sample;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [SMP_W-1:0]  i_raw_sample = '0;
    logic                     i_burst_end = 1'b0;
    logic [TIME_W-1:0]        i_now_ms = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [LVL_W-1:0]         o_level_spread;
    logic [LVL_W-1:0]         o_level_peak;
    logic [LVL_W-1:0]         o_level_rms;
    logic                     o_signal_seen;
    logic                     o_speech_active;
    logic [CODE_W-1:0]        o_event_code;
    logic [TIME_W-1:0]        o_speech_length_ms;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    burst_level_speech_detector_top #(.MAX_BURST(BURST_CAP)) uut (.*);

    always #5 i_clk = ~i_clk;

    t_sample sample_q[$];
    t_result level_q[$];

    t_cfg cfg = '{RST_SAMPLE_SHIFT, RST_SPEECH_THRESHOLD, RST_QUIET_THRESHOLD,
                  RST_MIN_SPEECH_MS, RST_SHORT_MAX_MS, RST_COOLDOWN_MS,
                  RST_SIGNAL_THRESHOLD};

    logic signed [SMP_W-1:0] acc_min = '0;
    logic signed [SMP_W-1:0] acc_max = '0;
    logic [LVL_W-1:0]        acc_peak = '0;
    logic [SUM_W-1:0]        acc_sum = '0;
    logic [CNT_W-1:0]        acc_cnt = '0;
    logic                    talking = 1'b0;
    logic [TIME_W-1:0]       talk_start = '0;
    logic [TIME_W-1:0]       hold_until = '0;
    logic                    heard = 1'b0;

    logic [TIME_W-1:0] clk_ms = '0;
    int                pushed = 0;
    int                errors = 0;
    int                cycle_cnt = 0;
    bit                idle_en = 1'b1;
    int                gap_left = 0;
    int                stall_left = 0;

    function automatic logic [LVL_W-1:0] clip_level(input logic [SMP_W-1:0] v);
        return (v > LVL_SAT) ? LVL_SAT : v[LVL_W-1:0];
    endfunction

    function automatic logic [SMP_W-1:0] int_sqrt(input logic [SUM_W-1:0] x);
        logic [SMP_W-1:0] r;
        logic [SMP_W-1:0] t;
        r = '0;
        for (int i = SMP_W - 1; i >= 0; i--) begin
            t = r | (SMP_W'(1) << i);
            if (SUM_W'(t) * SUM_W'(t) <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    task automatic level_step(input logic signed [SMP_W-1:0] raw, input logic last,
                              input logic [TIME_W-1:0] now);
        logic signed [SMP_W-1:0] v;
        logic [SMP_W-1:0]        mag;
        logic [SMP_W-1:0]        spread;
        logic [SMP_W-1:0]        root;
        logic [SMP_W-1:0]        dur;
        logic [SUM_W-1:0]        sq;
        t_result                 r;
        if (acc_cnt < BURST_CAP) begin
            v = raw >>> cfg.sample_shift;
            mag = v[SMP_W-1] ? -v : v;
            sq = SUM_W'(mag) * SUM_W'(mag);
            if (acc_cnt == 0 || v < acc_min) begin
                acc_min = v;
            end
            if (acc_cnt == 0 || v > acc_max) begin
                acc_max = v;
            end
            if (mag > acc_peak) begin
                acc_peak = clip_level(mag);
            end
            acc_sum = (acc_sum > ~sq) ? '1 : acc_sum + sq;
            acc_cnt = acc_cnt + 1'b1;
        end
        if (last) begin
            r = '0;
            spread = '0;
            root = '0;
            if (acc_cnt != 0) begin
                spread = acc_max - acc_min;
                r.level_peak = acc_peak;
                root = int_sqrt(acc_sum / acc_cnt);
            end
            if (spread > cfg.signal_threshold) begin
                heard = 1'b1;
            end
            r.event_code = EV_NONE;
            if (spread > cfg.speech_threshold) begin
                if (!talking) begin
                    talking = 1'b1;
                    talk_start = now;
                    r.event_code = EV_START;
                end
            end else if (talking && spread < cfg.quiet_threshold) begin
                dur = now - talk_start;
                talking = 1'b0;
                r.speech_length_ms = dur;
                if (dur < cfg.min_speech_ms) begin
                    r.event_code = EV_TOO_SHORT;
                end else if (now < hold_until) begin
                    r.event_code = EV_SUPPRESSED;
                end else begin
                    hold_until = now + cfg.cooldown_ms;
                    r.event_code = (dur <= cfg.short_max_ms) ? EV_SHORT_CMD : EV_LONG_CMD;
                end
            end
            r.level_spread = clip_level(spread);
            r.level_rms = clip_level(root);
            r.signal_seen = heard;
            r.speech_active = talking;
            level_q.push_back(r);
            acc_min = '0;
            acc_max = '0;
            acc_peak = '0;
            acc_sum = '0;
            acc_cnt = '0;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                level_step(i_raw_sample, i_burst_end, i_now_ms);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    i_in_valid <= 1'b0;
                    gap_left--;
                end else if (idle_en && $urandom_range(0, 9) == 0) begin
                    i_in_valid <= 1'b0;
                    gap_left = $urandom_range(0, 7);
                end else if (sample_q.size() != 0) begin
                    t_sample s;
                    s = sample_q.pop_front();
                    i_raw_sample <= s.raw;
                    i_burst_end <= s.last;
                    i_now_ms <= s.now;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (level_q.size() == 0) begin
                    $error("result transfer with no result expected");
                    errors++;
                end else begin
                    t_result e;
                    e = level_q.pop_front();
                    check_field("level_spread", e.level_spread, o_level_spread);
                    check_field("level_peak", e.level_peak, o_level_peak);
                    check_field("level_rms", e.level_rms, o_level_rms);
                    check_field("signal_seen", e.signal_seen, o_signal_seen);
                    check_field("speech_active", e.speech_active, o_speech_active);
                    check_field("event_code", e.event_code, o_event_code);
                    check_field("speech_length_ms", e.speech_length_ms, o_speech_length_ms);
                end
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 7);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SAMPLE_SHIFT:     cfg.sample_shift = val[SHIFT_W-1:0];
            REG_SPEECH_THRESHOLD: cfg.speech_threshold = val[LVL_W-1:0];
            REG_QUIET_THRESHOLD:  cfg.quiet_threshold = val[LVL_W-1:0];
            REG_MIN_SPEECH_MS:    cfg.min_speech_ms = val[MS_W-1:0];
            REG_SHORT_MAX_MS:     cfg.short_max_ms = val[MS_W-1:0];
            REG_COOLDOWN_MS:      cfg.cooldown_ms = val[MS_W-1:0];
            REG_SIGNAL_THRESHOLD: cfg.signal_threshold = val[LVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int shift, input int speech, input int quiet,
                              input int min_ms, input int short_ms, input int cool_ms,
                              input int sig);
        reg_write(REG_SAMPLE_SHIFT, shift);
        reg_write(REG_SPEECH_THRESHOLD, speech);
        reg_write(REG_QUIET_THRESHOLD, quiet);
        reg_write(REG_MIN_SPEECH_MS, min_ms);
        reg_write(REG_SHORT_MAX_MS, short_ms);
        reg_write(REG_COOLDOWN_MS, cool_ms);
        reg_write(REG_SIGNAL_THRESHOLD, sig);
    endtask

    task automatic push_item(input logic [SMP_W-1:0] raw, input logic last,
                             input logic [TIME_W-1:0] now);
        t_sample s;
        s.raw = raw;
        s.last = last;
        s.now = now;
        sample_q.push_back(s);
        pushed++;
    endtask

    // The first two samples sit at +amp and -amp in the shifted domain, amp clipped to what the
    // shift allows, so a burst of two or more samples has spread 2*amp; the bits below the shift are random.
    function automatic logic [SMP_W-1:0] shaped_raw(input int k, input longint amp);
        longint lim;
        longint a;
        longint v;
        lim = (64'sd1 <<< (31 - cfg.sample_shift)) - 1;
        a = (amp > lim) ? lim : amp;
        if (k == 0) begin
            v = a;
        end else if (k == 1) begin
            v = -a;
        end else begin
            v = longint'($urandom_range(0, 32'(2 * a))) - a;
        end
        return SMP_W'((v <<< cfg.sample_shift)
                      + longint'($urandom & ((32'd1 << cfg.sample_shift) - 32'd1)));
    endfunction

    task automatic push_burst(input t_burst_kind kind);
        int      n;
        longint  amp;
        longint  thr;
        t_sample s;
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(BURST_CAP - 2, BURST_CAP + 3)
                                         : $urandom_range(1, 12);
        case ($urandom_range(0, 3))
            0: clk_ms += $urandom_range(0, 40);
            1: clk_ms += $urandom_range(40, 250);
            2: clk_ms += $urandom_range(250, 900);
            default: clk_ms += $urandom_range(900, 4000);
        endcase
        case (kind)
            BK_LOUD: begin
                amp = cfg.speech_threshold / 2 + 1 + $urandom_range(0, cfg.speech_threshold / 4);
            end
            BK_QUIET: begin
                amp = (cfg.quiet_threshold < 2) ? 0
                                                : $urandom_range(0, cfg.quiet_threshold / 2 - 1);
            end
            BK_EDGE: begin
                case ($urandom_range(0, 2))
                    0: thr = cfg.speech_threshold;
                    1: thr = cfg.quiet_threshold;
                    default: thr = cfg.signal_threshold;
                endcase
                amp = thr / 2 + $urandom_range(0, 1);
            end
            default: begin
                amp = 0;
                clk_ms = $urandom;
            end
        endcase
        for (int k = 0; k < n; k++) begin
            s.raw = (kind == BK_NOISE) ? $urandom : shaped_raw(k, amp);
            s.last = (k == n - 1);
            s.now = s.last ? clk_ms : $urandom;
            sample_q.push_back(s);
        end
        pushed += n;
    endtask

    // Mostly speech segments: a run of loud bursts followed by quiet ones.
    task automatic random_phase(input int items);
        int stop_at;
        int pick;
        stop_at = pushed + items;
        while (pushed < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                repeat ($urandom_range(1, 5)) push_burst(BK_LOUD);
                repeat ($urandom_range(1, 3)) push_burst(BK_QUIET);
            end else if (pick < 9) begin
                push_burst(BK_EDGE);
            end else begin
                push_burst(BK_NOISE);
            end
        end
    endtask

    task automatic drain();
        do @(posedge i_clk); while (sample_q.size() != 0 || i_in_valid || level_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_item(32'h7FFF_FFFF, 1'b1, 32'd0);
        push_item(32'h8000_0000, 1'b0, $urandom);
        push_item(32'h7FFF_FFFF, 1'b1, 32'd1000);
        push_item(32'h0000_0000, 1'b1, 32'd1050);
        push_item(32'h8000_0000, 1'b0, $urandom);
        push_item(32'h7FFF_FFFF, 1'b1, 32'd2000);
        push_item(32'hFFFF_FFFF, 1'b1, 32'd2300);
        push_item(32'h8000_0000, 1'b0, $urandom);
        push_item(32'h7FFF_FFFF, 1'b1, 32'd2400);
        push_item(32'h0001_2345, 1'b1, 32'd3400);
        push_item(32'h8000_0000, 1'b0, $urandom);
        push_item(32'h7FFF_FFFF, 1'b1, 32'd5000);
        push_item(32'h0000_0000, 1'b1, 32'd6000);
        push_item(32'h0064_0000, 1'b0, $urandom);
        push_item(32'hFF9C_0000, 1'b1, 32'd6100);
        push_item(32'h8000_0000, 1'b0, $urandom);
        push_item(32'h7FFF_FFFF, 1'b1, 32'd10000);
        push_item(32'h0032_0000, 1'b0, $urandom);
        push_item(32'hFFCE_0000, 1'b1, 32'd10100);
        push_item(32'h0000_0000, 1'b1, 32'd10800);
        push_item(32'h8000_0000, 1'b0, $urandom);
        push_item(32'h7FFF_FFFF, 1'b1, 32'hFFFF_FF00);
        push_item(32'h0000_0000, 1'b1, 32'h0000_0100);
        clk_ms = 32'h0000_0100;
        drain();

        set_config(14, 800, 400, 120, 650, 1800, 50);
        random_phase(450);
        drain();

        set_config(4, 0, 0, 0, 0, 0, 0);
        random_phase(200);
        drain();

        set_config(31, LVL_SAT, LVL_SAT, 16'hFFFF, 16'hFFFF, 16'hFFFF, LVL_SAT);
        random_phase(100);
        drain();

        set_config(0, 28'h800_0000, 28'h400_0000, 100, 500, 2000, 1000);
        repeat (3) push_item(32'h8000_0000, 1'b0, $urandom);
        clk_ms += 10;
        push_item(32'h8000_0000, 1'b1, clk_ms);
        push_item(32'h8000_0000, 1'b0, $urandom);
        clk_ms += 10;
        push_item(32'h7FFF_FFFF, 1'b1, clk_ms);
        random_phase(150);
        drain();

        set_config(10, 3000, 2500, 50, 300, 600, 100);
        random_phase(450);
        drain();

        idle_en = 1'b0;
        set_config(16, 200, 150, 120, 650, 1800, 20);
        random_phase(400);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[burst_level_speech_detector_top.f]
hw/rtl/bld_pkg.sv
hw/rtl/bld_front.sv
hw/rtl/bld_queue.sv
hw/rtl/bld_back.sv
hw/rtl/burst_level_speech_detector_top.sv
hw/rtl/bld_checker.sv
tb/tb.sv
